[rtl/asalu_pkg.sv]
// Shared types, constants and operation codes for the ALU with condition flags.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package asalu_pkg;

	// Word and register-file geometry (register numbers are carried in IDX_W bits)
	localparam int DATA_WIDTH = 32;
	localparam int NUM_REGS   = 8;
	localparam int IDX_W      = 3;
	localparam int RF_AW      = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int AMT_W      = 5;

	// Operation codes
	typedef enum logic [3:0] {
		OP_MOV = 4'd0,
		OP_ADD = 4'd1,
		OP_SUB = 4'd2,
		OP_AND = 4'd3,
		OP_ORR = 4'd4,
		OP_XOR = 4'd5,
		OP_LSR = 4'd6,
		OP_LSL = 4'd7,
		OP_CMP = 4'd8,
		OP_TST = 4'd9
	} op_t;

	// Condition flags
	typedef struct packed {
		logic n;
		logic z;
		logic c;
		logic v;
	} flags_t;

	// What the execute unit hands back for one item
	typedef struct packed {
		logic [DATA_WIDTH-1:0] value;
		logic                  wr;
		logic [IDX_W-1:0]      wr_idx;
		flags_t                flags;
		logic                  illegal;
	} exec_res_t;

endpackage

`default_nettype wire

[rtl/asalu_regfile.sv]
// Register file: NUM_REGS words, one write port, two registered read ports with
// write-through so an item read at the edge of a write sees the new value.
// Depends on asalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asalu_regfile (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            rd_en,
	input  wire logic [asalu_pkg::IDX_W-1:0]      ra_a,
	input  wire logic [asalu_pkg::IDX_W-1:0]      ra_b,
	output logic      [asalu_pkg::DATA_WIDTH-1:0] rdata_a,
	output logic      [asalu_pkg::DATA_WIDTH-1:0] rdata_b,
	input  wire logic                            we,
	input  wire logic [asalu_pkg::IDX_W-1:0]      wa,
	input  wire logic [asalu_pkg::DATA_WIDTH-1:0] wd
);

	logic [asalu_pkg::DATA_WIDTH-1:0] mem [asalu_pkg::NUM_REGS];
	logic [asalu_pkg::NUM_REGS-1:0]   valid_q;
	logic [asalu_pkg::DATA_WIDTH-1:0] rd_a_nxt;
	logic [asalu_pkg::DATA_WIDTH-1:0] rd_b_nxt;
	logic [asalu_pkg::DATA_WIDTH-1:0] rdata_a_q;
	logic [asalu_pkg::DATA_WIDTH-1:0] rdata_b_q;

	// One read port: out of range reads zero, a write in flight wins, unwritten reads zero
	function automatic logic [asalu_pkg::DATA_WIDTH-1:0] rd_port(
		input logic [asalu_pkg::IDX_W-1:0]      ra,
		input logic                             w_en,
		input logic [asalu_pkg::IDX_W-1:0]      w_a,
		input logic [asalu_pkg::DATA_WIDTH-1:0] w_d,
		input logic [asalu_pkg::DATA_WIDTH-1:0] m_d,
		input logic                             m_v
	);
		logic [asalu_pkg::DATA_WIDTH-1:0] d;
		d = '0;
		if (int'(ra) < asalu_pkg::NUM_REGS) begin
			if (w_en && (w_a == ra))
				d = w_d;
			else if (m_v)
				d = m_d;
		end
		return d;
	endfunction

	always_comb begin
		rd_a_nxt = rd_port(ra_a, we, wa, wd, mem[ra_a[asalu_pkg::RF_AW-1:0]],
			valid_q[ra_a[asalu_pkg::RF_AW-1:0]]);
		rd_b_nxt = rd_port(ra_b, we, wa, wd, mem[ra_b[asalu_pkg::RF_AW-1:0]],
			valid_q[ra_b[asalu_pkg::RF_AW-1:0]]);
	end

	// Storage write
	always_ff @(posedge clk) begin
		if (we)
			mem[wa[asalu_pkg::RF_AW-1:0]] <= wd;
	end

	// Per-entry valid bits stand in for the all-zero reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[wa[asalu_pkg::RF_AW-1:0]] <= 1'b1;
		end
	end

	// Registered read data, captured when an item is taken in
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_a_q <= rd_a_nxt;
			rdata_b_q <= rd_b_nxt;
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

`default_nettype wire

[rtl/asalu_exec.sv]
// Execute unit: one instruction's value, register write and next NZCV flags.
// Purely combinational; depends on asalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asalu_exec (
	input  wire logic [3:0]                       action,
	input  wire logic                             set_flags,
	input  wire logic [asalu_pkg::IDX_W-1:0]       dest,
	input  wire logic [asalu_pkg::DATA_WIDTH-1:0]  a,
	input  wire logic [asalu_pkg::DATA_WIDTH-1:0]  b,
	input  wire logic [asalu_pkg::DATA_WIDTH-1:0]  imm,
	input  wire asalu_pkg::flags_t                 flags_cur,
	output asalu_pkg::exec_res_t                   res
);

	localparam int W = asalu_pkg::DATA_WIDTH;

	logic [W:0]                     sum;
	logic [W:0]                     diff;
	logic [W:0]                     shr_ext;
	logic [W:0]                     shl_ext;
	logic [asalu_pkg::AMT_W-1:0]    amt;
	logic [W-1:0]                   r;
	logic                           c_new;
	logic                           v_new;
	logic                           wr;
	logic                           setf;
	logic                           illegal;

	assign amt = imm[asalu_pkg::AMT_W-1:0];

	// Adder, subtractor and both shifters; the extra bit holds carry, borrow or the bit shifted out
	always_comb begin
		sum     = {1'b0, a} + {1'b0, b};
		diff    = {1'b0, a} - {1'b0, b};
		shr_ext = {a, 1'b0} >> amt;
		shl_ext = {1'b0, a} << amt;
	end

	// Operation select
	always_comb begin
		r       = '0;
		c_new   = flags_cur.c;
		v_new   = flags_cur.v;
		wr      = 1'b1;
		setf    = set_flags;
		illegal = 1'b0;
		case (asalu_pkg::op_t'(action))
			asalu_pkg::OP_MOV: r = imm;
			asalu_pkg::OP_ADD: begin
				r     = sum[W-1:0];
				c_new = sum[W];
				v_new = ~(a[W-1] ^ b[W-1]) & (a[W-1] ^ sum[W-1]);
			end
			asalu_pkg::OP_SUB, asalu_pkg::OP_CMP: begin
				r     = diff[W-1:0];
				c_new = ~diff[W];
				v_new = (a[W-1] ^ b[W-1]) & (a[W-1] ^ diff[W-1]);
				if (asalu_pkg::op_t'(action) == asalu_pkg::OP_CMP) begin
					wr   = 1'b0;
					setf = 1'b1;
				end
			end
			asalu_pkg::OP_AND: r = a & b;
			asalu_pkg::OP_ORR: r = a | b;
			asalu_pkg::OP_XOR: r = a ^ b;
			asalu_pkg::OP_TST: begin
				r    = a & b;
				wr   = 1'b0;
				setf = 1'b1;
			end
			asalu_pkg::OP_LSR: begin
				if (amt == '0) begin
					r = a;
				end else begin
					r     = shr_ext[W:1];
					c_new = shr_ext[0];
				end
			end
			asalu_pkg::OP_LSL: begin
				if (amt == '0) begin
					r = a;
				end else begin
					r     = shl_ext[W-1:0];
					c_new = shl_ext[W];
				end
			end
			default: begin
				illegal = 1'b1;
				wr      = 1'b0;
				setf    = 1'b0;
			end
		endcase
		// writes to a register number beyond the file are dropped
		if (int'(dest) >= asalu_pkg::NUM_REGS)
			wr = 1'b0;
	end

	// Pack the outcome
	always_comb begin
		res.value   = r;
		res.wr      = wr;
		res.wr_idx  = wr ? dest : '0;
		res.illegal = illegal;
		if (setf) begin
			res.flags.n = r[W-1];
			res.flags.z = (r == '0);
			res.flags.c = c_new;
			res.flags.v = v_new;
		end else begin
			res.flags = flags_cur;
		end
	end

endmodule

`default_nettype wire

[rtl/arm_style_alu_with_flags.sv]
// Top level of the data-processing ALU with NZCV flags: input stage, register
// file, execute unit and result register. Depends on asalu_pkg, asalu_regfile, asalu_exec.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | to block  | in_valid / in_ready   | action, set_flags, dest_index,
//          |           |                      | first_index, second_index, immediate
//  out     | from block| out_valid / out_ready | result_value, wrote_register, written_index,
//          |           |                      | negative_flag .. overflow_flag, illegal_op
//
// An accepted item passes through the input stage and the result register before out_valid
// rises; one item per clock is sustained while out_ready stays high.
// Operands are read from the register file at acceptance (with write-through), and
// the execute unit sits between the input stage and the result register.
// A stalled result holds the input stage; in_ready then follows out_ready.
// Reset clears the flags, the register file valid bits and both valid flops.
`timescale 1ns / 1ps
`default_nettype none

module arm_style_alu_with_flags (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [3:0]                       action,
	input  wire logic                             set_flags,
	input  wire logic [asalu_pkg::IDX_W-1:0]       dest_index,
	input  wire logic [asalu_pkg::IDX_W-1:0]       first_index,
	input  wire logic [asalu_pkg::IDX_W-1:0]       second_index,
	input  wire logic [asalu_pkg::DATA_WIDTH-1:0]  immediate,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic      [asalu_pkg::DATA_WIDTH-1:0]  result_value,
	output logic                                  wrote_register,
	output logic      [asalu_pkg::IDX_W-1:0]       written_index,
	output logic                                  negative_flag,
	output logic                                  zero_flag,
	output logic                                  carry_flag,
	output logic                                  overflow_flag,
	output logic                                  illegal_op
);

	logic                              vld_s1;
	logic [3:0]                        action_s1;
	logic                              set_flags_s1;
	logic [asalu_pkg::IDX_W-1:0]        dest_s1;
	logic [asalu_pkg::DATA_WIDTH-1:0]   imm_s1;
	logic [asalu_pkg::DATA_WIDTH-1:0]   a_s1;
	logic [asalu_pkg::DATA_WIDTH-1:0]   b_s1;
	asalu_pkg::flags_t                  flags_q;
	asalu_pkg::exec_res_t               res;
	asalu_pkg::exec_res_t               res_q;
	logic                              out_vld_q;
	logic                              accept;
	logic                              fire;

	// Handshake: the stage moves when the result register is free or being emptied
	assign fire     = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready = !vld_s1 || fire;
	assign accept   = in_valid && in_ready;

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1    <= action;
			set_flags_s1 <= set_flags;
			dest_s1      <= dest_index;
			imm_s1       <= immediate;
		end
	end

	// Register file; operands land in a_s1 / b_s1 alongside the input stage
	asalu_regfile u_rf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.ra_a    (first_index),
		.ra_b    (second_index),
		.rdata_a (a_s1),
		.rdata_b (b_s1),
		.we      (fire && res.wr),
		.wa      (res.wr_idx),
		.wd      (res.value)
	);

	asalu_exec u_exec (
		.action    (action_s1),
		.set_flags (set_flags_s1),
		.dest      (dest_s1),
		.a         (a_s1),
		.b         (b_s1),
		.imm       (imm_s1),
		.flags_cur (flags_q),
		.res       (res)
	);

	// Flags and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (fire)
				flags_q <= res.flags;
			if (fire)
				out_vld_q <= 1'b1;
			else if (out_ready)
				out_vld_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (fire)
			res_q <= res;
	end

	assign out_valid      = out_vld_q;
	assign result_value   = res_q.illegal ? '0 : res_q.value;
	assign wrote_register = res_q.wr;
	assign written_index  = res_q.wr_idx;
	assign negative_flag  = res_q.flags.n;
	assign zero_flag      = res_q.flags.z;
	assign carry_flag     = res_q.flags.c;
	assign overflow_flag  = res_q.flags.v;
	assign illegal_op     = res_q.illegal;

endmodule

`default_nettype wire

[rtl/asalu_checker.sv]
// Port-level checks for arm_style_alu_with_flags, and the bind that attaches them.
// Depends on asalu_pkg and the top level's port list.
`timescale 1ns / 1ps
`default_nettype none

module asalu_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             in_ready,
	input wire logic                             out_valid,
	input wire logic                             out_ready,
	input wire logic [asalu_pkg::DATA_WIDTH-1:0]  result_value,
	input wire logic                             wrote_register,
	input wire logic [asalu_pkg::IDX_W-1:0]       written_index,
	input wire logic                             illegal_op
);

	// A stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_value)
			&& $stable(wrote_register) && $stable(written_index) && $stable(illegal_op))
		else $error("result item changed while stalled");

	// An undefined operation reports zero and writes nothing
	a_illegal_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && illegal_op |-> !wrote_register && (result_value == '0))
		else $error("illegal item wrote a register or gave a value");

	// No write means written_index reads zero
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !wrote_register |-> (written_index == '0))
		else $error("written_index set without a write");

	// With the result register empty the input is never held off
	a_input_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with the result register empty");

endmodule

bind arm_style_alu_with_flags asalu_checker u_asalu_chk (.*);

`default_nettype wire
